### src/gsba_pkg.sv
// Shared constants, types and codes for the square bin allocator.
`default_nettype none
package gsba_pkg;

	localparam int NUM_BINS = 1024;
	localparam int BIN_W    = $clog2(NUM_BINS);
	localparam int USED_W   = BIN_W + 1;
	localparam int IDX_W    = 11;

	localparam int SQ_W   = 13;
	localparam int ONE_W  = 7;
	localparam int SUB_W  = 7;
	localparam int LAT_W  = 15;
	localparam int LON_W  = 16;
	localparam int MAG_W  = 16;
	localparam int CNT_W  = 32;
	localparam int DATA_W = 56;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		MODE_1DEG   = 2'd0,
		MODE_2P5DEG = 2'd1,
		MODE_5DEG   = 2'd2,
		MODE_10DEG  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [SQ_W-1:0]  square;
		logic [SUB_W-1:0] sub;
	} key_t;

	typedef struct packed {
		logic [IDX_W-1:0] bin_index;
		logic             bin_new;
		logic             went_overflow;
		logic [SUB_W-1:0] sub_key;
		logic [CNT_W-1:0] bin_count;
	} res_t;

endpackage
`default_nettype wire

### src/gsba_front.sv
// Front end: accepts stations, holds the mode register and builds the bin key.
`default_nettype none
module gsba_front import gsba_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [SQ_W-1:0]  in_square,
	input  wire logic [ONE_W-1:0] in_one,
	input  wire logic [LAT_W-1:0] in_lat,
	input  wire logic [LON_W-1:0] in_lon,
	output logic                  push,
	output key_t                  push_key,
	input  wire logic             full
);

	localparam int Q_W         = 7;
	localparam int RECIP_W     = 11;
	localparam int RECIP_1000  = 1048;  // floor(2^20 / 1000), never overestimates
	localparam int RECIP_SH    = 20;
	localparam int THOUSAND    = 1000;
	localparam int CELL_SIZE   = 250;   // 25 tenths of a degree, in hundredths
	localparam int CELLS_ROW   = 4;
	localparam int TEN         = 10;
	localparam int RECIP_10    = 205;
	localparam int HALF_DIGIT  = 5;
	localparam int HALF_SQUARE = 50;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam int REM_W       = MAG_W + 1;

	mode_t               mode_q;
	logic                v_s1;
	logic [SQ_W-1:0]     sq_s1;
	logic [ONE_W-1:0]    one_s1;
	logic [MAG_W-1:0]    lat_mag_s1, lon_mag_s1;
	logic [Q_W-1:0]      lat_q_s1, lon_q_s1;

	logic                accept;
	logic signed [MAG_W-1:0] lat_ext;
	logic signed [MAG_W:0]   lon_ext;
	logic [MAG_W-1:0]    lat_mag, lon_mag;
	logic [PROD_W-1:0]   lat_prod, lon_prod;
	logic [1:0]          lat_cell, lon_cell;
	logic [14:0]         one_prod;
	logic [3:0]          one_tens;
	logic [ONE_W-1:0]    one_units;
	logic [SUB_W-1:0]    sub;

	// Position of a magnitude within its 10-degree square, in quarters.
	function automatic logic [1:0] quarter(input logic [MAG_W-1:0] mag,
	                                       input logic [Q_W-1:0] q);
		logic [REM_W-1:0] r;
		begin
			r = REM_W'(mag) - REM_W'(REM_W'(q) * REM_W'(THOUSAND));
			if (r >= REM_W'(THOUSAND)) begin
				r = r - REM_W'(THOUSAND);
			end
			if (r >= REM_W'(3 * CELL_SIZE)) begin
				quarter = 2'd3;
			end else if (r >= REM_W'(2 * CELL_SIZE)) begin
				quarter = 2'd2;
			end else if (r >= REM_W'(CELL_SIZE)) begin
				quarter = 2'd1;
			end else begin
				quarter = 2'd0;
			end
		end
	endfunction

	assign cfg_ready = 1'b1;
	assign push      = v_s1 && !full;
	assign in_ready  = !v_s1 || !full;
	assign accept    = in_valid && in_ready;

	assign lat_ext  = MAG_W'(signed'(in_lat));
	assign lon_ext  = (MAG_W + 1)'(signed'(in_lon));
	assign lat_mag  = lat_ext[MAG_W-1] ? MAG_W'(-lat_ext) : lat_ext;
	assign lon_mag  = lon_ext[MAG_W] ? MAG_W'(-lon_ext) : lon_ext[MAG_W-1:0];
	assign lat_prod = PROD_W'(lat_mag) * PROD_W'(RECIP_1000);
	assign lon_prod = PROD_W'(lon_mag) * PROD_W'(RECIP_1000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_10DEG;
			v_s1   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= mode_t'(cfg_data);
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1      <= in_square;
			one_s1     <= in_one;
			lat_mag_s1 <= lat_mag;
			lon_mag_s1 <= lon_mag;
			lat_q_s1   <= lat_prod[RECIP_SH +: Q_W];
			lon_q_s1   <= lon_prod[RECIP_SH +: Q_W];
		end
	end

	assign lat_cell  = quarter(lat_mag_s1, lat_q_s1);
	assign lon_cell  = quarter(lon_mag_s1, lon_q_s1);
	assign one_prod  = 15'(one_s1) * 15'(RECIP_10);
	assign one_tens  = one_prod[14:11];
	assign one_units = one_s1 - ONE_W'(ONE_W'(one_tens) * ONE_W'(TEN));

	always_comb begin
		unique case (mode_q)
			MODE_1DEG:   sub = one_s1;
			MODE_2P5DEG: sub = SUB_W'(SUB_W'(lat_cell) * SUB_W'(CELLS_ROW))
			                   + SUB_W'(lon_cell);
			MODE_5DEG:   sub = SUB_W'({(one_s1 >= ONE_W'(HALF_SQUARE)),
			                           (one_units >= ONE_W'(HALF_DIGIT))});
			MODE_10DEG:  sub = '0;
			default:     sub = '0;
		endcase
	end

	assign push_key.square = sq_s1;
	assign push_key.sub    = sub;

endmodule
`default_nettype wire

### src/gsba_queue.sv
// Short queue of keyed items between the front end and the bin search.
`default_nettype none
module gsba_queue import gsba_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire key_t push_key,
	output logic      full,
	input  wire logic pop,
	output key_t      pop_key,
	output logic      empty
);

	key_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full    = cnt_q == (QPTR_W + 1)'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign pop_key = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_key;
		end
	end

endmodule
`default_nettype wire

### src/gsba_back.sv
// Back end: linear search of the key table, bin allocation and count update.
`default_nettype none
module gsba_back import gsba_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic empty,
	input  wire key_t pop_key,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_RDCNT = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t            state_q;
	key_t              key_q;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] addr_q;
	logic [BIN_W-1:0]  chk_idx_q;
	logic              chk_vld_q;
	logic [CNT_W-1:0]  ovf_cnt_q;
	logic [IDX_W-1:0]  bin_q;
	logic              new_q, ovf_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	res_t              out_q;

	key_t              key_mem [NUM_BINS];
	logic [CNT_W-1:0]  cnt_mem [NUM_BINS];
	key_t              key_rd_q;
	logic [CNT_W-1:0]  cnt_rd_q;

	logic hit, all_issued, key_re, cnt_re, commit;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c == '1) ? c : c + 1'b1;
	endfunction

	assign hit        = chk_vld_q && (key_rd_q == key_q);
	assign all_issued = addr_q == used_q;
	assign key_re     = (state_q == ST_SCAN) && !hit && !all_issued;
	assign cnt_re     = (state_q == ST_SCAN) && hit;
	assign commit     = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign pop        = (state_q == ST_IDLE) && !empty;
	assign out_valid  = out_valid_q;
	assign out_res    = out_q;

	always_ff @(posedge clk) begin
		if (key_re) begin
			key_rd_q <= key_mem[addr_q[BIN_W-1:0]];
		end
		if (commit && new_q) begin
			key_mem[used_q[BIN_W-1:0]] <= key_q;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[chk_idx_q];
		end
		if (commit && !ovf_q) begin
			cnt_mem[bin_q[BIN_W-1:0]] <= count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			key_q <= pop_key;
		end
		if (key_re) begin
			chk_idx_q <= addr_q[BIN_W-1:0];
		end
		if (state_q == ST_SCAN && hit) begin
			bin_q <= IDX_W'(chk_idx_q);
			new_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (state_q == ST_SCAN && all_issued) begin
			if (used_q != USED_W'(NUM_BINS)) begin
				bin_q   <= IDX_W'(used_q);
				new_q   <= 1'b1;
				ovf_q   <= 1'b0;
				count_q <= CNT_W'(1);
			end else begin
				bin_q   <= IDX_W'(NUM_BINS);
				new_q   <= 1'b0;
				ovf_q   <= 1'b1;
				count_q <= sat_inc(ovf_cnt_q);
			end
		end
		if (state_q == ST_RDCNT) begin
			count_q <= sat_inc(cnt_rd_q);
		end
		if (commit) begin
			out_q.bin_index     <= bin_q;
			out_q.bin_new       <= new_q;
			out_q.went_overflow <= ovf_q;
			out_q.sub_key       <= key_q.sub;
			out_q.bin_count     <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			addr_q      <= '0;
			chk_vld_q   <= 1'b0;
			ovf_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					addr_q    <= '0;
					chk_vld_q <= 1'b0;
					if (!empty) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// One read goes out per cycle; the compare works on the registered read data (key_rd_q).
					if (hit) begin
						state_q <= ST_RDCNT;
					end else if (all_issued) begin
						state_q <= ST_DONE;
					end else begin
						addr_q    <= addr_q + 1'b1;
						chk_vld_q <= 1'b1;
					end
				end
				ST_RDCNT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (new_q) begin
							used_q <= used_q + 1'b1;
						end
						if (ovf_q) begin
							ovf_cnt_q <= count_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/geo_square_bin_allocator_top.sv
// Path: the front-end stage registers the inputs and builds the key, the queue holds it,
// the back end scans the key table one read per cycle, reads the count on a match and
// loads the output register before m_tvalid rises. The back end takes a new item only
// after the last result is committed, so the scan of the key memory sets the item rate.
// Input items wait in the front-end register and the queue while the scan runs; the output register holds one result.
// Reset (arst_n low) empties the table, clears the overflow count and sets the mode to
// 10-degree squares; no clearing pass is needed.
`default_nettype none
module geo_square_bin_allocator_top import gsba_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_data,    // square_mode
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// square_ten[12:0], square_one[19:13], lat_centi[34:20], lon_centi[50:35], zeros
	input  wire logic [DATA_W-1:0] s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// bin_index[10:0], bin_new[11], went_overflow[12], sub_key[19:13],
	// bin_count[51:20], zeros
	output logic [DATA_W-1:0]      m_tdata
);

	logic push, full, pop, empty;
	key_t push_key, pop_key;
	res_t res;

	gsba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_square (s_tdata[12:0]),
		.in_one    (s_tdata[19:13]),
		.in_lat    (s_tdata[34:20]),
		.in_lon    (s_tdata[50:35]),
		.push      (push),
		.push_key  (push_key),
		.full      (full)
	);

	gsba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_key (push_key),
		.full     (full),
		.pop      (pop),
		.pop_key  (pop_key),
		.empty    (empty)
	);

	gsba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_key   (pop_key),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {4'b0, res.bin_count, res.sub_key, res.went_overflow,
	                  res.bin_new, res.bin_index};

endmodule
`default_nettype wire

### tb/station_bin_checker.sv
// Checker for the square bin allocator: predicts every result and compares it with the output.
module station_bin_checker import gsba_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [1:0]        cfg_data,    // square_mode
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	// square_ten[12:0], square_one[19:13], lat_centi[34:20], lon_centi[50:35], zeros
	input  wire logic [DATA_W-1:0] s_tdata,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	// bin_index[10:0], bin_new[11], went_overflow[12], sub_key[19:13],
	// bin_count[51:20], zeros
	input  wire logic [DATA_W-1:0] m_tdata,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	mode_t            mode_q;
	logic [SQ_W-1:0]  stored_square [NUM_BINS];
	logic [SUB_W-1:0] stored_sub [NUM_BINS];
	int unsigned      used_bins;
	logic [CNT_W-1:0] station_count [NUM_BINS+1];
	res_t             expected_bins [$];
	res_t             seen_result;
	res_t             due_result;
	int               errors = 0;

	assign fail_count = errors;

	// Tenths of a degree inside the 10-degree square, truncated.
	function automatic int unsigned tenths_of(int centi);
		int unsigned mag;
		mag = (centi < 0) ? -centi : centi;
		return (mag / 10) % 100;
	endfunction

	function automatic res_t assign_bin(logic [DATA_W-1:0] item);
		logic [SQ_W-1:0]  sq;
		logic [ONE_W-1:0] one;
		int               lat;
		int               lon;
		logic [SUB_W-1:0] sub;
		int unsigned      j;
		res_t             r;
		sq  = item[12:0];
		one = item[19:13];
		lat = $signed(item[34:20]);
		lon = $signed(item[50:35]);
		case (mode_q)
			MODE_1DEG:   sub = one;
			MODE_2P5DEG: sub = SUB_W'((tenths_of(lat) / 25) * 4 + tenths_of(lon) / 25);
			MODE_5DEG:   sub = SUB_W'(((one / 10 >= 5) ? 2 : 0) + ((one % 10 >= 5) ? 1 : 0));
			default:     sub = '0;
		endcase
		// Keys are compared as stored, whatever mode stored them.
		j = 0;
		while (j < used_bins && !(stored_square[j] == sq && stored_sub[j] == sub))
			j++;
		r = '0;
		if (j >= used_bins) begin
			if (used_bins < NUM_BINS) begin
				j = used_bins;
				stored_square[j] = sq;
				stored_sub[j] = sub;
				used_bins++;
				r.bin_new = 1'b1;
			end else begin
				j = NUM_BINS;
				r.went_overflow = 1'b1;
			end
		end
		if (station_count[j] != '1)
			station_count[j]++;
		r.bin_index = IDX_W'(j);
		r.sub_key = sub;
		r.bin_count = station_count[j];
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_10DEG;
			used_bins = 0;
			foreach (station_count[i])
				station_count[i] = '0;
			expected_bins.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_q = mode_t'(cfg_data);
			// A result leaving now belongs to an earlier item, so match it before adding new ones.
			if (m_tvalid && m_tready) begin
				seen_result.bin_index = m_tdata[10:0];
				seen_result.bin_new = m_tdata[11];
				seen_result.went_overflow = m_tdata[12];
				seen_result.sub_key = m_tdata[19:13];
				seen_result.bin_count = m_tdata[51:20];
				if (expected_bins.size() == 0) begin
					$display("%0t: result with no item waiting, bin_index %0d", $time,
						seen_result.bin_index);
					errors++;
				end else begin
					due_result = expected_bins.pop_front();
					check_field("bin_index", due_result.bin_index, seen_result.bin_index);
					check_field("bin_new", due_result.bin_new, seen_result.bin_new);
					check_field("went_overflow", due_result.went_overflow,
						seen_result.went_overflow);
					check_field("sub_key", due_result.sub_key, seen_result.sub_key);
					check_field("bin_count", due_result.bin_count, seen_result.bin_count);
				end
			end
			if (s_tvalid && s_tready)
				expected_bins.push_back(assign_bin(s_tdata));
			pending <= expected_bins.size();
		end
	end

endmodule

### tb/testbench.sv
// Bench top for the square bin allocator: clock, reset, stimulus, watchdog and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gsba_pkg::*;

	localparam int STALL_LIMIT = 10000;
	localparam int TAIL_CYCLES = 1100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	int                fail_count;
	int                pending;
	logic              calm = 1'b0;
	int                quiet_cycles = 0;

	logic [SQ_W-1:0]  square_pool [8] = '{0, 1, 17, 1234, 4095, 5000, 7999, 8191};
	logic [ONE_W-1:0] digit_pool [6] = '{0, 5, 49, 50, 99, 127};
	mode_t            phase_modes [4] = '{MODE_2P5DEG, MODE_1DEG, MODE_10DEG, MODE_5DEG};

	geo_square_bin_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	station_bin_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_station(input logic [SQ_W-1:0] sq, input logic [ONE_W-1:0] one,
			input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
		int gap;
		s_tdata <= {{(DATA_W - SQ_W - ONE_W - LAT_W - LON_W){1'b0}}, lon, lat, one, sq};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_mode(input mode_t m);
		wait_drained();
		cfg_data <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly a small set of squares and digits so that bins get hit again, plus some noise.
	task automatic random_station();
		logic [SQ_W-1:0]  sq;
		logic [ONE_W-1:0] one;
		logic [LAT_W-1:0] lat;
		logic [LON_W-1:0] lon;
		sq = ($urandom_range(0, 99) < 85) ? square_pool[$urandom_range(0, 7)] : SQ_W'($urandom());
		one = ($urandom_range(0, 99) < 75) ? digit_pool[$urandom_range(0, 5)] :
			ONE_W'($urandom());
		lat = ($urandom_range(0, 99) < 85) ? LAT_W'(int'($urandom_range(0, 18000)) - 9000) :
			LAT_W'($urandom());
		lon = ($urandom_range(0, 99) < 85) ? LON_W'(int'($urandom_range(0, 36000)) - 18000) :
			LON_W'($urandom());
		send_station(sq, one, lat, lon);
	endtask

	initial begin
		int run;
		int stall;
		int r;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 24);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			r = $urandom_range(0, 99);
			stall = (calm || r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) :
				$urandom_range(20, 80);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 1-degree keys, field extremes and a repeat that must land in the same bin.
		write_mode(MODE_1DEG);
		send_station(0, 0, 0, 0);
		send_station(8191, 127, 0, 0);
		send_station(7999, 99, 9000, LON_W'(-18000));
		send_station(0, 0, 100, LON_W'(-100));
		send_station(100, 3, 0, 0);

		// Quadrants, including digits above 99; quadrant 3 finds the key stored in 1-degree mode.
		write_mode(MODE_5DEG);
		send_station(100, 55, 0, 0);
		send_station(100, 49, 0, 0);
		send_station(100, 50, 0, 0);
		send_station(100, 127, 0, 0);
		send_station(42, 4, 0, 0);

		// 2.5-degree cells: range limits, cell edges and positions outside their range.
		write_mode(MODE_2P5DEG);
		send_station(200, 0, LAT_W'(-9000), 18000);
		send_station(200, 0, 249, 251);
		send_station(200, 0, 999, LON_W'(-999));
		send_station(200, 0, 15'h3fff, 16'h7fff);
		send_station(200, 0, 15'h4000, 16'h8000);
		send_station(200, 0, LAT_W'(-2500), 7499);

		// With no sub-key, square 0 matches the key stored by the first item.
		write_mode(MODE_10DEG);
		send_station(8191, 127, 15'h7fff, 16'hffff);
		send_station(0, 64, 0, 0);

		for (int p = 0; p < 4; p++) begin
			calm = (p == 2);
			write_mode(phase_modes[p]);
			for (int n = 0; n < 100; n++) begin
				if (p == 0 && n == 50)
					wait_drained();
				random_station();
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
src/gsba_pkg.sv
src/gsba_front.sv
src/gsba_queue.sv
src/gsba_back.sv
src/geo_square_bin_allocator_top.sv
tb/station_bin_checker.sv
tb/testbench.sv
